// ===== hdl/pfa_pkg.sv =====
// Package for the page frame allocator: controller/datapath command and status
// structs, result codes, register indexes and the entry record layout.
// No dependencies.
package pfa_pkg;

   // Register indexes on the CSR write channel
   localparam logic [7:0] CFG_DIRECTORY_ID = 8'd0;
   localparam logic [7:0] CFG_BASE_ADDRESS = 8'd1;

   // Register reset values
   localparam logic [31:0] BASE_RESET = 32'h01E8_4800;

   // Request operations
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // Page commands
   localparam logic [1:0] PCMD_NONE  = 2'd0;
   localparam logic [1:0] PCMD_MAP   = 2'd1;
   localparam logic [1:0] PCMD_UNMAP = 2'd2;

   // Kind of result the controller asks the datapath to build
   localparam logic [1:0] KIND_MAP   = 2'd0;
   localparam logic [1:0] KIND_UNMAP = 2'd1;
   localparam logic [1:0] KIND_MISS  = 2'd2;
   localparam logic [1:0] KIND_FULL  = 2'd3;

   // One frame table record
   typedef struct packed {
      logic        live;
      logic [31:0] virt;
      logic [7:0]  space;
      logic [15:0] stamp;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_req;      // latch request payload
      logic       stack_rd;      // pop: read top of free stack
      logic       take_stack;    // frame index from free stack read data
      logic       take_created;  // frame index from created count
      logic       alloc_write;   // write live record, advance stamp
      logic       scan_start;    // clear search state
      logic       scan_step;     // advance search by one entry
      logic       release_frame; // clear live bit, push on free stack
      logic       load_out;      // load result register
      logic [1:0] kind;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic free_empty;
      logic table_full;
      logic stack_full;
      logic scan_done;
      logic found;
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/page_frame_allocator_top.sv =====
// Top level of the page frame allocator: controller plus datapath.
// Uses pfa_pkg, pfa_control, pfa_datapath (and pfa_ram through it).
//
// One request is handled at a time. An allocate that creates a new frame goes
// from acceptance through S_ALLOC to S_FINISH; one that pops a freed frame from
// the free stack first passes S_POP for the stack memory read; on a full table
// it goes straight to S_FINISH. A free walks the frame table memory one
// entry per cycle through its single read port, then passes S_RELEASE (not on a
// miss) before S_FINISH, which waits until the result register is free. The
// next request is accepted in the cycle after the result is loaded, while that
// result may still wait on rsp_tready. No clearing pass follows reset: only
// frames below the created count are ever read, so the block is ready at once.
// CSR writes belong in idle periods; csr_ready is always high.
module page_frame_allocator_top
   import pfa_pkg::*;
#(
   parameter int NUM_FRAMES  = 64,
   parameter int FRAME_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // virt_address[31:0], writable[32], user_mode[33], zero
   input  logic        req_tuser,   // func[0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // phys_address[31:0], map_virt_address[63:32],
                                    // map_writable[64], map_user[65], space_id[73:66], zero
   output logic [3:0]  rsp_tuser,   // status[1:0], page_command[3:2]
   // CSR write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   pfa_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   pfa_datapath #(
      .NUM_FRAMES  (NUM_FRAMES),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_virt_address (req_tdata[31:0]),
      .req_writable     (req_tdata[32]),
      .req_user_mode    (req_tdata[33]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

// ===== hdl/pfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pfa_datapath.sv =====
// Datapath of the page frame allocator: CSRs, counters, frame table and free
// stack memories, sequential search and the result register. Uses pfa_pkg, pfa_ram.
module pfa_datapath
   import pfa_pkg::*;
#(
   parameter int NUM_FRAMES  = 64,
   parameter int FRAME_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data,
   // request payload
   input  logic [31:0] req_virt_address,
   input  logic        req_writable,
   input  logic        req_user_mode,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,
   // control
   input  cmd_type     cmd,
   output stat_type    stat
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);
   localparam logic [CNT_W-1:0] NUM_CNT   = CNT_W'(NUM_FRAMES);
   localparam logic [31:0]      FRAME_MUL = 32'(FRAME_BYTES);

   // Configuration registers
   logic [7:0]  dir_ff,  dir_in;
   logic [31:0] base_ff, base_in;

   // Counters
   logic [CNT_W-1:0] free_ff,    free_in;
   logic [CNT_W-1:0] created_ff, created_in;
   logic [15:0]      stamp_ff,   stamp_in;

   // Request payload and working frame index
   logic [31:0]      va_ff;
   logic             wr_ff, us_ff;
   logic [IDX_W-1:0] idx_ff;

   // Search state
   logic [CNT_W-1:0] scan_addr_ff, scan_addr_in;
   logic             rd_valid_ff,  rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             found_ff,     found_in;
   logic [IDX_W-1:0] best_ff,      best_in;
   logic [15:0]      best_age_ff,  best_age_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff, out_pcmd_ff;
   logic [31:0] out_phys_ff, out_virt_ff;
   logic        out_w_ff, out_u_ff;
   logic [7:0]  out_space_ff;

   // Memory ports
   entry_type        ent_wdata, ent_rdata;
   logic             ent_we;
   logic [IDX_W-1:0] ent_waddr;
   logic             scan_issue;
   logic             stk_we;
   logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_rdata;

   logic        match;
   logic [15:0] age;
   logic [31:0] phys;

   pfa_ram #(.WIDTH($bits(entry_type)), .DEPTH(NUM_FRAMES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (scan_issue),
      .rd_addr (scan_addr_ff[IDX_W-1:0]),
      .rd_data (ent_rdata)
   );

   pfa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_FRAMES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (best_ff),
      .rd_en   (cmd.stack_rd),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign csr_ready = 1'b1;

   // Decode CSR writes; unknown indexes are dropped
   always_comb begin
      dir_in  = dir_ff;
      base_in = base_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CFG_DIRECTORY_ID: dir_in  = csr_data[7:0];
            CFG_BASE_ADDRESS: base_in = csr_data;
            default: ;
         endcase
      end
   end

   // Frame table writes: live record on allocate, cleared live bit on release
   always_comb begin
      ent_we    = cmd.alloc_write || cmd.release_frame;
      ent_waddr = cmd.release_frame ? best_ff : idx_ff;
      ent_wdata.live  = cmd.alloc_write;
      ent_wdata.virt  = va_ff;
      ent_wdata.space = dir_ff;
      ent_wdata.stamp = stamp_ff;
   end

   // Free stack: push at free count, pop reads the entry below it
   assign stk_we    = cmd.release_frame;
   assign stk_waddr = free_ff[IDX_W-1:0];
   assign stk_raddr = IDX_W'(free_ff - CNT_W'(1));

   // Counters
   always_comb begin
      free_in    = free_ff;
      created_in = created_ff;
      stamp_in   = stamp_ff;
      if (cmd.stack_rd) begin
         free_in = free_ff - CNT_W'(1);
      end else if (cmd.release_frame) begin
         free_in = free_ff + CNT_W'(1);
      end
      if (cmd.take_created) begin
         created_in = created_ff + CNT_W'(1);
      end
      if (cmd.alloc_write) begin
         stamp_in = stamp_ff + 16'd1;
      end
   end

   // Search one entry per cycle over all created frames
   assign scan_issue = cmd.scan_step && (scan_addr_ff != created_ff);
   assign match = rd_valid_ff && ent_rdata.live && (ent_rdata.virt == va_ff)
                  && (ent_rdata.space == dir_ff);
   assign age   = stamp_ff - 16'd1 - ent_rdata.stamp;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      rd_valid_in  = 1'b0;
      found_in     = found_ff;
      best_in      = best_ff;
      best_age_in  = best_age_ff;
      if (cmd.scan_start) begin
         scan_addr_in = '0;
         found_in     = 1'b0;
      end else if (cmd.scan_step) begin
         rd_valid_in = scan_issue;
         if (scan_issue) begin
            scan_addr_in = scan_addr_ff + CNT_W'(1);
         end
         // Strict compare keeps the lowest index on equal age
         if (match && (!found_ff || (age < best_age_ff))) begin
            found_in    = 1'b1;
            best_in     = rd_idx_ff;
            best_age_in = age;
         end
      end
   end

   // Physical address of the working frame
   assign phys = base_ff + 32'({{(32-IDX_W){1'b0}}, idx_ff} * FRAME_MUL);

   // Result register: load on command, drop when taken
   assign out_valid_in = cmd.load_out || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= '0;
         base_ff      <= BASE_RESET;
         free_ff      <= '0;
         created_ff   <= '0;
         stamp_ff     <= '0;
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         dir_ff       <= dir_in;
         base_ff      <= base_in;
         free_ff      <= free_in;
         created_ff   <= created_in;
         stamp_ff     <= stamp_in;
         scan_addr_ff <= scan_addr_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
      rd_idx_ff   <= scan_addr_ff[IDX_W-1:0];
      if (cmd.load_req) begin
         va_ff <= req_virt_address;
         wr_ff <= req_writable;
         us_ff <= req_user_mode;
      end
      if (cmd.take_stack) begin
         idx_ff <= stk_rdata;
      end else if (cmd.take_created) begin
         idx_ff <= created_ff[IDX_W-1:0];
      end else if (cmd.release_frame) begin
         idx_ff <= best_ff;
      end
      if (cmd.load_out) begin
         out_status_ff <= STATUS_DONE;
         out_pcmd_ff   <= PCMD_NONE;
         out_phys_ff   <= '0;
         out_virt_ff   <= '0;
         out_w_ff      <= 1'b0;
         out_u_ff      <= 1'b0;
         out_space_ff  <= '0;
         case (cmd.kind)
            KIND_MAP: begin
               out_pcmd_ff  <= PCMD_MAP;
               out_phys_ff  <= phys;
               out_virt_ff  <= va_ff;
               out_w_ff     <= wr_ff;
               out_u_ff     <= us_ff;
               out_space_ff <= dir_ff;
            end
            KIND_UNMAP: begin
               out_pcmd_ff  <= PCMD_UNMAP;
               out_phys_ff  <= phys;
               out_virt_ff  <= va_ff;
               out_space_ff <= dir_ff;
            end
            KIND_MISS: out_status_ff <= STATUS_MISS;
            default:   out_status_ff <= STATUS_FULL;
         endcase
      end
   end

   // Status to the controller
   always_comb begin
      stat.free_empty = (free_ff == '0);
      stat.table_full = (created_ff == NUM_CNT);
      stat.stack_full = (free_ff == NUM_CNT);
      stat.scan_done  = (scan_addr_ff == created_ff) && !rd_valid_ff;
      stat.found      = found_ff;
      stat.out_free   = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_space_ff, out_u_ff, out_w_ff, out_virt_ff, out_phys_ff};
   assign rsp_tuser  = {out_pcmd_ff, out_status_ff};

endmodule

// ===== hdl/pfa_control.sv =====
// Controller of the page frame allocator: sequences allocate and free
// transactions and drives the datapath commands. Uses pfa_pkg.
module pfa_control
   import pfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     req_func,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_POP     = 3'd1;
   localparam logic [2:0] S_ALLOC   = 3'd2;
   localparam logic [2:0] S_SCAN    = 3'd3;
   localparam logic [2:0] S_RELEASE = 3'd4;
   localparam logic [2:0] S_FINISH  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff,  kind_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.kind = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               if (req_func == FUNC_FREE) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end else if (!stat.free_empty) begin
                  cmd.stack_rd = 1'b1;
                  state_in     = S_POP;
               end else if (!stat.table_full) begin
                  cmd.take_created = 1'b1;
                  state_in         = S_ALLOC;
               end else begin
                  kind_in  = KIND_FULL;
                  state_in = S_FINISH;
               end
            end
         end
         S_POP: begin
            cmd.take_stack = 1'b1;
            state_in       = S_ALLOC;
         end
         S_ALLOC: begin
            cmd.alloc_write = 1'b1;
            kind_in         = KIND_MAP;
            state_in        = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               if (stat.found && !stat.stack_full) begin
                  state_in = S_RELEASE;
               end else begin
                  kind_in  = KIND_MISS;
                  state_in = S_FINISH;
               end
            end
         end
         S_RELEASE: begin
            cmd.release_frame = 1'b1;
            kind_in           = KIND_UNMAP;
            state_in          = S_FINISH;
         end
         S_FINISH: begin
            // Hold until the result register can take the result
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_MAP;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule
